// ===== rtl/core/anxb_pkg.sv =====
// Shared types and constants of the Annex B NAL unit splitter.
`default_nettype none

package anxb_pkg;

  localparam logic [1:0] KIND_HEAD = 2'd0;
  localparam logic [1:0] KIND_PAY  = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  localparam logic [7:0] ZERO_BYTE  = 8'h00;
  localparam logic [7:0] START_BYTE = 8'h01;
  localparam logic [7:0] EP_BYTE    = 8'h03;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0] nz;
    logic       has_tail;
    logic [1:0] tail_kind;
    logic [7:0] tail_byte;
    logic       long_code;
  } op_t;

endpackage

`default_nettype wire

// ===== rtl/core/anxb_if.sv =====
// Valid/ready channel interfaces for input and result words.
`default_nettype none

interface anxb_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;

  modport source (output valid, func, data_byte, input ready);
  modport sink (input valid, func, data_byte, output ready);
endinterface

interface anxb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [4:0] nal_type;
  logic [1:0] ref_idc;
  logic       long_start_code;
  logic       last_in_run;

  modport source (output valid, kind, out_byte, nal_type, ref_idc, long_start_code,
                  last_in_run, input ready);
  modport sink (input valid, kind, out_byte, nal_type, ref_idc, long_start_code,
                last_in_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/anxb_front.sv =====
// Front end: start-code search, zero holding and escape filtering per input word.
`default_nettype none

module anxb_front
  import anxb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  anxb_in_if.sink   in_ch,
  input  wire logic queue_full,
  output logic      push,
  output op_t       op
);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_HEAD = 2'd1;
  localparam logic [1:0] PH_PAY  = 2'd2;

  logic [1:0] phase, phase_next;
  logic [1:0] held_zeros, held_zeros_next;
  logic [1:0] escape_zero_run, escape_zero_run_next;
  logic       four_byte_code, four_byte_code_next;
  logic       accept;
  logic       is_zero;
  logic       is_start;
  logic [2:0] run_sum;
  logic       emit;

  assign in_ch.ready = !queue_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_zero     = (in_ch.data_byte == ZERO_BYTE);
  assign is_start    = (in_ch.data_byte == START_BYTE) && (held_zeros >= 2'd2);
  assign run_sum     = {1'b0, escape_zero_run} + {1'b0, held_zeros};
  assign push        = accept && emit;

  always_comb begin
    phase_next           = phase;
    held_zeros_next      = held_zeros;
    escape_zero_run_next = escape_zero_run;
    four_byte_code_next  = four_byte_code;
    op                   = '0;
    op.long_code         = four_byte_code;
    if (in_ch.func) begin
      if (phase == PH_HEAD) begin
        op.has_tail  = 1'b1;
        op.tail_kind = KIND_END;
      end else if (phase == PH_PAY) begin
        op.nz        = held_zeros;
        op.has_tail  = 1'b1;
        op.tail_kind = KIND_END;
      end
      phase_next           = PH_HUNT;
      held_zeros_next      = 2'd0;
      escape_zero_run_next = 2'd0;
      four_byte_code_next  = 1'b0;
    end else if (phase == PH_HEAD) begin
      op.has_tail          = 1'b1;
      op.tail_kind         = KIND_HEAD;
      op.tail_byte         = in_ch.data_byte;
      phase_next           = PH_PAY;
      held_zeros_next      = 2'd0;
      escape_zero_run_next = 2'd0;
    end else if (phase == PH_PAY) begin
      if (is_zero) begin
        if (held_zeros == 2'd3) begin
          op.nz = 2'd1;
          if (escape_zero_run < 2'd2) begin
            escape_zero_run_next = escape_zero_run + 2'd1;
          end
        end else begin
          held_zeros_next = held_zeros + 2'd1;
        end
      end else if (is_start) begin
        op.has_tail          = 1'b1;
        op.tail_kind         = KIND_END;
        four_byte_code_next  = (held_zeros == 2'd3);
        phase_next           = PH_HEAD;
        held_zeros_next      = 2'd0;
        escape_zero_run_next = 2'd0;
      end else begin
        op.nz                = held_zeros;
        held_zeros_next      = 2'd0;
        escape_zero_run_next = 2'd0;
        if (!((in_ch.data_byte == EP_BYTE) && (run_sum >= 3'd2))) begin
          op.has_tail  = 1'b1;
          op.tail_kind = KIND_PAY;
          op.tail_byte = in_ch.data_byte;
        end
      end
    end else begin
      phase_next = PH_HUNT;
      if (is_zero) begin
        if (held_zeros < 2'd3) begin
          held_zeros_next = held_zeros + 2'd1;
        end
      end else if (is_start) begin
        four_byte_code_next  = (held_zeros == 2'd3);
        phase_next           = PH_HEAD;
        held_zeros_next      = 2'd0;
        escape_zero_run_next = 2'd0;
      end else begin
        held_zeros_next = 2'd0;
      end
    end
    emit = op.has_tail || (op.nz != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      held_zeros      <= 2'd0;
      escape_zero_run <= 2'd0;
      four_byte_code  <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      held_zeros      <= held_zeros_next;
      escape_zero_run <= escape_zero_run_next;
      four_byte_code  <= four_byte_code_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HEAD) |-> (held_zeros == 2'd0))
    else $error("held zeros while expecting header");

  assert property (@(posedge clk) disable iff (rst)
    (escape_zero_run != 2'd3))
    else $error("escape run beyond saturation");

  assert property (@(posedge clk) disable iff (rst)
    (phase != PH_PAY) |-> (escape_zero_run == 2'd0))
    else $error("escape run outside payload");

endmodule

`default_nettype wire

// ===== rtl/core/anxb_queue.sv =====
// Short queue of decoded operations between front and back.
`default_nettype none

module anxb_queue
  import anxb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  op_t       push_op,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output op_t       head_op
);

  op_t                 slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;

  assign full       = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("queue count overflow");

  assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");

  assert property (@(posedge clk) disable iff (rst)
    !(pop && !head_valid))
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== rtl/core/anxb_back.sv =====
// Back end: expands queued operations into result words through an output register.
`default_nettype none

module anxb_back
  import anxb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  head_valid,
  input  op_t        head_op,
  output logic       pop,
  anxb_out_if.source out_ch
);

  logic [1:0] cnt;
  logic       zero_step;
  logic       step_last;
  logic       load;
  logic [1:0] step_kind;
  logic [7:0] step_byte;

  assign zero_step = (cnt != head_op.nz);
  assign step_last = zero_step ? ((cnt == head_op.nz - 2'd1) && !head_op.has_tail) : 1'b1;
  assign step_kind = zero_step ? KIND_PAY : head_op.tail_kind;
  assign step_byte = zero_step ? ZERO_BYTE : head_op.tail_byte;
  assign load      = head_valid && (!out_ch.valid || out_ch.ready);
  assign pop       = load && step_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= 2'd0;
      out_ch.valid <= 1'b0;
    end else begin
      if (load) begin
        out_ch.valid <= 1'b1;
        cnt          <= step_last ? 2'd0 : cnt + 2'd1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ch.kind            <= step_kind;
      out_ch.out_byte        <= step_byte;
      out_ch.nal_type        <= (step_kind == KIND_HEAD) ? step_byte[4:0] : 5'd0;
      out_ch.ref_idc         <= (step_kind == KIND_HEAD) ? step_byte[6:5] : 2'd0;
      out_ch.long_start_code <= head_op.long_code;
      out_ch.last_in_run     <= step_last;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (cnt < head_op.nz || cnt == head_op.nz))
    else $error("zero counter past queued count");

  assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.last_in_run) |->
      (out_ch.kind == KIND_PAY && out_ch.out_byte == ZERO_BYTE))
    else $error("non-final result is not a released zero");

  assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> (cnt == 2'd0))
    else $error("zero counter busy with empty queue");

endmodule

`default_nettype wire

// ===== rtl/core/annexb_nal_unit_splitter.sv =====
// Top level of the Annex B NAL unit splitter: front end, queue and back end.
// An accepted byte's operation is queued, then loaded into the output register.
// Throughput: one byte per cycle while each byte gives at most one result and the
// output is ready; the back end sends one result per cycle, up to 4 per byte.
// Reset (rst, synchronous): hunting for a start code, queue empty, no result valid.
`default_nettype none

module annexb_nal_unit_splitter
  import anxb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  anxb_in_if.sink    in_ch,
  anxb_out_if.source out_ch
);

  logic push;
  op_t  push_op;
  logic full;
  logic pop;
  logic head_valid;
  op_t  head_op;

  anxb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .queue_full (full),
    .push       (push),
    .op         (push_op)
  );

  anxb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  anxb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire
